[design/plmd_pkg.sv]
package plmd_pkg;

  // Fixed-point format of coordinates and coefficients: signed Q4.28.
  localparam int FRAC_BITS  = 28;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] wide_t;

  localparam wide_t Q_ONE    = 64'sd268435456;
  localparam wide_t RND_HALF = 64'sd134217728;
  localparam wide_t S32_MAX  = 64'sd2147483647;
  localparam wide_t S32_MIN  = -64'sd2147483648;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X = 3'd0,
    REG_INV_FOCAL_Y = 3'd1,
    REG_CENTER_X    = 3'd2,
    REG_CENTER_Y    = 3'd3,
    REG_RADIAL_K1   = 3'd4,
    REG_RADIAL_K2   = 3'd5,
    REG_TANG_P1     = 3'd6,
    REG_TANG_P2     = 3'd7
  } reg_idx_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [23:0] inv_focal_x;
    logic [23:0] inv_focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
    q_t          radial_k1;
    q_t          radial_k2;
    q_t          tangential_p1;
    q_t          tangential_p2;
  } cfg_t;

  // A saturated value together with its overflow flag.
  typedef struct packed {
    q_t   val;
    logic clip;
  } sat_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic sat_t sat32(input wide_t v);
    sat_t r;
    r.clip = 1'b1;
    if (v > S32_MAX) begin
      r.val = q_t'(S32_MAX);
    end else if (v < S32_MIN) begin
      r.val = q_t'(S32_MIN);
    end else begin
      r.val  = q_t'(v);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  // Round a raw Q8.56 product to Q4.28 (half toward plus infinity) and clamp.
  function automatic sat_t rnd_sat(input wide_t p);
    wide_t t;
    t = p + RND_HALF;
    return sat32(t >>> FRAC_BITS);
  endfunction

endpackage

[design/plmd_if.sv]
// Pixel coordinate channel.
interface plmd_pix_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COORD_BITS-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

// Normalized coordinate result channel.
interface plmd_norm_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] norm_x;
  logic signed [31:0] norm_y;
  logic               clipped;

  modport source (output valid, output norm_x, output norm_y, output clipped, input ready);
  modport sink (input valid, input norm_x, input norm_y, input clipped, output ready);
endinterface

// Configuration write channel.
interface plmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [plmd_pkg::CFG_IDX_W-1:0]  index;
  logic [plmd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/plmd_cfg_regs.sv]
module plmd_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  plmd_cfg_if.sink       cfg,
  output plmd_pkg::cfg_t regs
);
  import plmd_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register file with decode of the write index.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.inv_focal_x   <= 24'd33554;
      regs.inv_focal_y   <= 24'd33554;
      regs.center_x      <= 16'd5112;
      regs.center_y      <= 16'd3832;
      regs.radial_k1     <= '0;
      regs.radial_k2     <= '0;
      regs.tangential_p1 <= '0;
      regs.tangential_p2 <= '0;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_INV_FOCAL_X: regs.inv_focal_x   <= cfg.data[23:0];
        REG_INV_FOCAL_Y: regs.inv_focal_y   <= cfg.data[23:0];
        REG_CENTER_X:    regs.center_x      <= cfg.data[15:0];
        REG_CENTER_Y:    regs.center_y      <= cfg.data[15:0];
        REG_RADIAL_K1:   regs.radial_k1     <= q_t'(cfg.data);
        REG_RADIAL_K2:   regs.radial_k2     <= q_t'(cfg.data);
        REG_TANG_P1:     regs.tangential_p1 <= q_t'(cfg.data);
        REG_TANG_P2:     regs.tangential_p2 <= q_t'(cfg.data);
        default: ;
      endcase
    end
  end

endmodule

[design/pixel_lens_distortion_map.sv]
// Brown-Conrady lens distortion map. Each transfer on pix carries one integer
// pixel (column, row); after centering on the principal point and scaling by
// the reciprocal focal lengths, the radial factor 1 + k1 r^2 + k2 r^4 + k3 r^6
// and the tangential terms from p1 and p2 are applied, giving the distorted
// normalized coordinate in signed Q4.28 on norm. The block is an eleven-stage
// pipeline: it takes one pixel every clock cycle when norm is not stalled.
// Each stage holds its item while the next one is full and cannot advance,
// so a stall on norm fills bubbles first and only then holds pix. Every
// intermediate value is clamped to 32 bits and any clamp sets clipped on that
// result. Configuration registers may be written only while no pixel is in
// flight; k3 is fixed by the K3_COEFF parameter.
module pixel_lens_distortion_map #(
  parameter int COORD_BITS = 12,
  parameter int K3_COEFF   = 0
) (
  input  logic          clk,
  input  logic          rst,
  plmd_pix_if.sink      pix,
  plmd_norm_if.source   norm,
  plmd_cfg_if.sink      cfg
);
  import plmd_pkg::*;

  localparam int N_STG = 11;
  // Centered coordinate width: covers pixel*16 and the 16-bit center, plus sign.
  localparam int DX_W  = ((COORD_BITS + 4 > 16) ? COORD_BITS + 4 : 16) + 1;
  localparam int PX_W  = DX_W + 25;
  localparam q_t K3_Q  = q_t'(K3_COEFF);

  cfg_t regs;

  plmd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Stage valid bits and per-stage advance enables.
  logic [N_STG-1:0] vld;
  logic [N_STG-1:0] en;
  logic [N_STG-1:0] vld_in;

  always_comb begin
    en[N_STG-1] = !vld[N_STG-1] || norm.ready;
    for (int k = N_STG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_in    = {vld[N_STG-2:0], pix.valid};
  assign pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < N_STG; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  // Stage 1: center on the principal point and scale by 1/f (exact Q.28).
  logic signed [DX_W-1:0] dx_x, dx_y;
  logic signed [PX_W-1:0] s1_px, s1_py;

  assign dx_x = DX_W'({pix.pixel_col, 4'b0000}) - DX_W'(regs.center_x);
  assign dx_y = DX_W'({pix.pixel_row, 4'b0000}) - DX_W'(regs.center_y);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_px <= PX_W'(dx_x) * PX_W'($signed({1'b0, regs.inv_focal_x}));
      s1_py <= PX_W'(dx_y) * PX_W'($signed({1'b0, regs.inv_focal_y}));
    end
  end

  // Stage 2: clamp xd, yd and form the raw squares and cross product.
  sat_t  c2_x, c2_y;
  q_t    s2_xd, s2_yd;
  wide_t s2_xx, s2_yy, s2_xy;
  logic  s2_clip;

  assign c2_x = sat32(wide_t'(s1_px));
  assign c2_y = sat32(wide_t'(s1_py));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_xd   <= c2_x.val;
      s2_yd   <= c2_y.val;
      s2_xx   <= wide_t'(c2_x.val) * wide_t'(c2_x.val);
      s2_yy   <= wide_t'(c2_y.val) * wide_t'(c2_y.val);
      s2_xy   <= wide_t'(c2_x.val) * wide_t'(c2_y.val);
      s2_clip <= c2_x.clip | c2_y.clip;
    end
  end

  // Stage 3: round x^2, y^2, xy and sum r^2.
  sat_t c3_x2, c3_y2, c3_xy, c3_r2;
  q_t   s3_xd, s3_yd, s3_x2, s3_y2, s3_xy, s3_r2;
  logic s3_clip;

  always_comb begin
    c3_x2 = rnd_sat(s2_xx);
    c3_y2 = rnd_sat(s2_yy);
    c3_xy = rnd_sat(s2_xy);
    c3_r2 = sat32(wide_t'(c3_x2.val) + wide_t'(c3_y2.val));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_xd   <= s2_xd;
      s3_yd   <= s2_yd;
      s3_x2   <= c3_x2.val;
      s3_y2   <= c3_y2.val;
      s3_xy   <= c3_xy.val;
      s3_r2   <= c3_r2.val;
      s3_clip <= s2_clip | c3_x2.clip | c3_y2.clip | c3_xy.clip | c3_r2.clip;
    end
  end

  // Stage 4: raw r^4, k1 r^2, p1 xy, p2 xy; the tangential sums r^2 + 2x^2, r^2 + 2y^2.
  sat_t  c4_ex, c4_ey;
  q_t    s4_xd, s4_yd, s4_r2, s4_ex, s4_ey;
  wide_t s4_r2r2, s4_k1r2, s4_p1xy, s4_p2xy;
  logic  s4_clip;

  always_comb begin
    c4_ex = sat32(wide_t'(s3_r2) + (wide_t'(s3_x2) <<< 1));
    c4_ey = sat32(wide_t'(s3_r2) + (wide_t'(s3_y2) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_xd   <= s3_xd;
      s4_yd   <= s3_yd;
      s4_r2   <= s3_r2;
      s4_ex   <= c4_ex.val;
      s4_ey   <= c4_ey.val;
      s4_r2r2 <= wide_t'(s3_r2) * wide_t'(s3_r2);
      s4_k1r2 <= wide_t'(regs.radial_k1) * wide_t'(s3_r2);
      s4_p1xy <= wide_t'(regs.tangential_p1) * wide_t'(s3_xy);
      s4_p2xy <= wide_t'(regs.tangential_p2) * wide_t'(s3_xy);
      s4_clip <= s3_clip | c4_ex.clip | c4_ey.clip;
    end
  end

  // Stage 5: round the stage 4 products; raw p2 (r^2+2x^2) and p1 (r^2+2y^2).
  sat_t  c5_r4, c5_k1, c5_p1xy, c5_p2xy;
  q_t    s5_xd, s5_yd, s5_r2, s5_r4, s5_mk1, s5_p1xy, s5_p2xy;
  wide_t s5_p2e, s5_p1e;
  logic  s5_clip;

  always_comb begin
    c5_r4   = rnd_sat(s4_r2r2);
    c5_k1   = rnd_sat(s4_k1r2);
    c5_p1xy = rnd_sat(s4_p1xy);
    c5_p2xy = rnd_sat(s4_p2xy);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_xd   <= s4_xd;
      s5_yd   <= s4_yd;
      s5_r2   <= s4_r2;
      s5_r4   <= c5_r4.val;
      s5_mk1  <= c5_k1.val;
      s5_p1xy <= c5_p1xy.val;
      s5_p2xy <= c5_p2xy.val;
      s5_p2e  <= wide_t'(regs.tangential_p2) * wide_t'(s4_ex);
      s5_p1e  <= wide_t'(regs.tangential_p1) * wide_t'(s4_ey);
      s5_clip <= s4_clip | c5_r4.clip | c5_k1.clip | c5_p1xy.clip | c5_p2xy.clip;
    end
  end

  // Stage 6: tangential terms tx, ty; raw r^6 and k2 r^4.
  sat_t  c6_p2e, c6_p1e, c6_tx, c6_ty;
  q_t    s6_xd, s6_yd, s6_mk1, s6_tx, s6_ty;
  wide_t s6_r4r2, s6_k2r4;
  logic  s6_clip;

  always_comb begin
    c6_p2e = rnd_sat(s5_p2e);
    c6_p1e = rnd_sat(s5_p1e);
    c6_tx  = sat32((wide_t'(s5_p1xy) <<< 1) + wide_t'(c6_p2e.val));
    c6_ty  = sat32(wide_t'(c6_p1e.val) + (wide_t'(s5_p2xy) <<< 1));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_xd   <= s5_xd;
      s6_yd   <= s5_yd;
      s6_mk1  <= s5_mk1;
      s6_tx   <= c6_tx.val;
      s6_ty   <= c6_ty.val;
      s6_r4r2 <= wide_t'(s5_r4) * wide_t'(s5_r2);
      s6_k2r4 <= wide_t'(regs.radial_k2) * wide_t'(s5_r4);
      s6_clip <= s5_clip | c6_p2e.clip | c6_p1e.clip | c6_tx.clip | c6_ty.clip;
    end
  end

  // Stage 7: round r^6 and k2 r^4.
  sat_t c7_r6, c7_k2;
  q_t   s7_xd, s7_yd, s7_mk1, s7_mk2, s7_r6, s7_tx, s7_ty;
  logic s7_clip;

  always_comb begin
    c7_r6 = rnd_sat(s6_r4r2);
    c7_k2 = rnd_sat(s6_k2r4);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_xd   <= s6_xd;
      s7_yd   <= s6_yd;
      s7_mk1  <= s6_mk1;
      s7_mk2  <= c7_k2.val;
      s7_r6   <= c7_r6.val;
      s7_tx   <= s6_tx;
      s7_ty   <= s6_ty;
      s7_clip <= s6_clip | c7_r6.clip | c7_k2.clip;
    end
  end

  // Stage 8: raw k3 r^6.
  q_t    s8_xd, s8_yd, s8_mk1, s8_mk2, s8_tx, s8_ty;
  wide_t s8_k3r6;
  logic  s8_clip;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_xd   <= s7_xd;
      s8_yd   <= s7_yd;
      s8_mk1  <= s7_mk1;
      s8_mk2  <= s7_mk2;
      s8_tx   <= s7_tx;
      s8_ty   <= s7_ty;
      s8_k3r6 <= wide_t'(K3_Q) * wide_t'(s7_r6);
      s8_clip <= s7_clip;
    end
  end

  // Stage 9: radial factor 1 + k1 r^2 + k2 r^4 + k3 r^6.
  sat_t c9_k3, c9_fac;
  q_t   s9_xd, s9_yd, s9_fac, s9_tx, s9_ty;
  logic s9_clip;

  always_comb begin
    c9_k3  = rnd_sat(s8_k3r6);
    c9_fac = sat32(Q_ONE + wide_t'(s8_mk1) + wide_t'(s8_mk2) + wide_t'(c9_k3.val));
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_xd   <= s8_xd;
      s9_yd   <= s8_yd;
      s9_fac  <= c9_fac.val;
      s9_tx   <= s8_tx;
      s9_ty   <= s8_ty;
      s9_clip <= s8_clip | c9_k3.clip | c9_fac.clip;
    end
  end

  // Stage 10: raw xd * fac and yd * fac.
  wide_t s10_xf, s10_yf;
  q_t    s10_tx, s10_ty;
  logic  s10_clip;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_xf   <= wide_t'(s9_xd) * wide_t'(s9_fac);
      s10_yf   <= wide_t'(s9_yd) * wide_t'(s9_fac);
      s10_tx   <= s9_tx;
      s10_ty   <= s9_ty;
      s10_clip <= s9_clip;
    end
  end

  // Stage 11: add the tangential terms; this is the output register.
  sat_t c11_xf, c11_yf, c11_nx, c11_ny;
  q_t   s11_nx, s11_ny;
  logic s11_clip;

  always_comb begin
    c11_xf = rnd_sat(s10_xf);
    c11_yf = rnd_sat(s10_yf);
    c11_nx = sat32(wide_t'(c11_xf.val) + wide_t'(s10_tx));
    c11_ny = sat32(wide_t'(c11_yf.val) + wide_t'(s10_ty));
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_nx   <= c11_nx.val;
      s11_ny   <= c11_ny.val;
      s11_clip <= s10_clip | c11_xf.clip | c11_yf.clip | c11_nx.clip | c11_ny.clip;
    end
  end

  assign norm.valid   = vld[N_STG-1];
  assign norm.norm_x  = s11_nx;
  assign norm.norm_y  = s11_ny;
  assign norm.clipped = s11_clip;

`ifndef SYNTHESIS
  // A draining output never blocks the input side.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    norm.ready |-> pix.ready)
    else $error("pixel input blocked while output drains");

  // The pipeline is empty right after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (vld == '0))
    else $error("stage valid set after reset");

  // A full first stage that cannot advance keeps its product.
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && !en[1]) |=> (vld[0] && $stable(s1_px) && $stable(s1_py)))
    else $error("stalled first stage lost its item");

  // A full output stage that is not taken stays full.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[N_STG-1] && !norm.ready) |=> (vld[N_STG-1] && $stable(s11_nx)))
    else $error("stalled result dropped");
`endif

endmodule

[tb/sv/lens_distortion_checker.sv]
`timescale 1ns / 100ps

module lens_distortion_checker #(
  parameter int COORD_BITS = 12,
  parameter int K3_COEFF   = 0
) (
  input  logic clk,
  input  logic rst,
  plmd_pix_if  pix,
  plmd_norm_if norm,
  plmd_cfg_if  cfg,
  output int   mismatch_count,
  output int   pending_results
);
  import plmd_pkg::*;

  typedef struct packed {
    q_t   x;
    q_t   y;
    logic clip;
  } norm_point_t;

  cfg_t        lens_regs;
  norm_point_t expected_points[$];
  int          fail_total;
  bit          sat_seen;

  assign mismatch_count = fail_total;

  // Clamp to the signed 32-bit range and remember that a clamp happened.
  function automatic longint clamp32(input longint v);
    if (v > S32_MAX) begin
      sat_seen = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat_seen = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // Q4.28 product, rounded to nearest with ties toward plus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return clamp32((a * b + RND_HALF) >>> FRAC_BITS);
  endfunction

  // Expected distorted normalized coordinate of one pixel.
  function automatic norm_point_t distort_pixel(input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row);
    norm_point_t p;
    longint k1, k2, k3, p1, p2;
    longint xd, yd, x2, y2, xy, r2, r4, r6, fac, tx, ty;
    k1 = longint'(signed'(lens_regs.radial_k1));
    k2 = longint'(signed'(lens_regs.radial_k2));
    p1 = longint'(signed'(lens_regs.tangential_p1));
    p2 = longint'(signed'(lens_regs.tangential_p2));
    k3 = clamp32(longint'(K3_COEFF));
    sat_seen = 1'b0;

    // Center on the principal point and scale; the product is exactly Q.28.
    xd = clamp32((longint'(col) * 16 - longint'(lens_regs.center_x))
                 * longint'(lens_regs.inv_focal_x));
    yd = clamp32((longint'(row) * 16 - longint'(lens_regs.center_y))
                 * longint'(lens_regs.inv_focal_y));

    x2 = qmul(xd, xd);
    y2 = qmul(yd, yd);
    xy = qmul(xd, yd);
    r2 = clamp32(x2 + y2);
    r4 = qmul(r2, r2);
    r6 = qmul(r4, r2);

    // Radial factor and tangential terms.
    fac = clamp32(Q_ONE + qmul(k1, r2) + qmul(k2, r4) + qmul(k3, r6));
    tx  = clamp32(2 * qmul(p1, xy) + qmul(p2, clamp32(r2 + 2 * x2)));
    ty  = clamp32(qmul(p1, clamp32(r2 + 2 * y2)) + 2 * qmul(p2, xy));

    p.x    = q_t'(clamp32(qmul(xd, fac) + tx));
    p.y    = q_t'(clamp32(qmul(yd, fac) + ty));
    p.clip = sat_seen;
    return p;
  endfunction

  task automatic note_mismatch(input string field, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
    end
  endtask

  // Track register writes, predict each accepted pixel, check each result transfer.
  always @(posedge clk) begin
    norm_point_t want;
    if (rst) begin
      lens_regs.inv_focal_x   <= 24'd33554;
      lens_regs.inv_focal_y   <= 24'd33554;
      lens_regs.center_x      <= 16'd5112;
      lens_regs.center_y      <= 16'd3832;
      lens_regs.radial_k1     <= '0;
      lens_regs.radial_k2     <= '0;
      lens_regs.tangential_p1 <= '0;
      lens_regs.tangential_p2 <= '0;
      expected_points.delete();
      pending_results <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (reg_idx_t'(cfg.index))
          REG_INV_FOCAL_X: lens_regs.inv_focal_x   <= cfg.data[23:0];
          REG_INV_FOCAL_Y: lens_regs.inv_focal_y   <= cfg.data[23:0];
          REG_CENTER_X:    lens_regs.center_x      <= cfg.data[15:0];
          REG_CENTER_Y:    lens_regs.center_y      <= cfg.data[15:0];
          REG_RADIAL_K1:   lens_regs.radial_k1     <= cfg.data;
          REG_RADIAL_K2:   lens_regs.radial_k2     <= cfg.data;
          REG_TANG_P1:     lens_regs.tangential_p1 <= cfg.data;
          REG_TANG_P2:     lens_regs.tangential_p2 <= cfg.data;
          default: ;
        endcase
      end

      if (pix.valid && pix.ready) begin
        expected_points.push_back(distort_pixel(pix.pixel_col, pix.pixel_row));
      end

      if (norm.valid && norm.ready) begin
        if (expected_points.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("%0t: result transfer with no pixel outstanding, x=%0d y=%0d",
                     $realtime, norm.norm_x, norm.norm_y);
          end
        end else begin
          want = expected_points.pop_front();
          if (norm.norm_x !== want.x) note_mismatch("norm_x", want.x, norm.norm_x);
          if (norm.norm_y !== want.y) note_mismatch("norm_y", want.y, norm.norm_y);
          if (norm.clipped !== want.clip) begin
            note_mismatch("clipped", 32'(want.clip), 32'(norm.clipped));
          end
        end
      end

      pending_results <= expected_points.size();
    end
  end

endmodule

[tb/sv/pixel_lens_distortion_map_tb.sv]
`timescale 1ns / 100ps

module pixel_lens_distortion_map_tb;
  import plmd_pkg::*;

  localparam int COORD_BITS     = 12;
  localparam int K3_COEFF       = 0;
  localparam int PIX_MAX        = (1 << COORD_BITS) - 1;
  localparam int RESET_CYCLES   = 12;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 24;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_PIXELS   = 188;
  localparam int QUIET_PHASE    = 1;
  localparam int HOLD_PHASE     = 3;
  localparam int PAUSE_PHASE    = 5;

  logic       clk;
  logic       rst;
  logic       idle_on;
  logic [7:0] hold_reqs;
  logic [7:0] hold_served = '0;
  int         mismatch_count;
  int         pending_results;

  plmd_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch();
  plmd_norm_if norm_ch();
  plmd_cfg_if  cfg_ch();

  pixel_lens_distortion_map #(
    .COORD_BITS(COORD_BITS),
    .K3_COEFF  (K3_COEFF)
  ) uut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .norm(norm_ch),
    .cfg (cfg_ch)
  );

  lens_distortion_checker #(
    .COORD_BITS(COORD_BITS),
    .K3_COEFF  (K3_COEFF)
  ) distortion_check (
    .clk            (clk),
    .rst            (rst),
    .pix            (pix_ch),
    .norm           (norm_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    norm_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        norm_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      norm_ch.ready <= !(idle_on && $urandom_range(99) < 19);
    end
  end

  // Give up when no transfer of any kind has happened for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (norm_ch.valid && norm_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("pixel_lens_distortion_map verification failed");
    $finish;
  end

  // Offer one pixel, with random idle cycles ahead of it, until it transfers.
  task automatic send_pixel(input int col, input int row);
    while (idle_on && $urandom_range(99) < 19) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid     <= 1'b1;
    pix_ch.pixel_col <= COORD_BITS'(col);
    pix_ch.pixel_row <= COORD_BITS'(row);
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Stop offering pixels and wait until every expected result has arrived.
  task automatic drain_pipeline();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_results == 0);
    @(posedge clk);
  endtask

  // Write every register once, in index order.
  task automatic load_regs(input cfg_t r);
    reg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      case (idx)
        REG_INV_FOCAL_X: cfg_ch.data <= 32'(r.inv_focal_x);
        REG_INV_FOCAL_Y: cfg_ch.data <= 32'(r.inv_focal_y);
        REG_CENTER_X:    cfg_ch.data <= 32'(r.center_x);
        REG_CENTER_Y:    cfg_ch.data <= 32'(r.center_y);
        REG_RADIAL_K1:   cfg_ch.data <= r.radial_k1;
        REG_RADIAL_K2:   cfg_ch.data <= r.radial_k2;
        REG_TANG_P1:     cfg_ch.data <= r.tangential_p1;
        REG_TANG_P2:     cfg_ch.data <= r.tangential_p2;
        default: ;
      endcase
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_ch.valid <= 1'b0;
  endtask

  // Either a lens that looks like a real camera or fully random register bits.
  function automatic cfg_t draw_lens_setting(input bit wild);
    cfg_t r;
    if (wild) begin
      r.inv_focal_x   = 24'($urandom);
      r.inv_focal_y   = 24'($urandom);
      r.center_x      = 16'($urandom);
      r.center_y      = 16'($urandom);
      r.radial_k1     = q_t'($urandom);
      r.radial_k2     = q_t'($urandom);
      r.tangential_p1 = q_t'($urandom);
      r.tangential_p2 = q_t'($urandom);
    end else begin
      r.inv_focal_x   = 24'($urandom_range(120000, 4000));
      r.inv_focal_y   = 24'($urandom_range(120000, 4000));
      r.center_x      = 16'($urandom);
      r.center_y      = 16'($urandom);
      r.radial_k1     = q_t'($signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
      r.radial_k2     = q_t'($signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000);
      r.tangential_p1 = q_t'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
      r.tangential_p2 = q_t'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
    end
    return r;
  endfunction

  // Stimulus: directed corners and special cases, then random phases.
  initial begin
    int col;
    int row;
    rst              <= 1'b1;
    idle_on          <= 1'b1;
    hold_reqs        <= '0;
    pix_ch.valid     <= 1'b0;
    pix_ch.pixel_col <= '0;
    pix_ch.pixel_row <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_INV_FOCAL_X;
    cfg_ch.data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers as they come out of reset; corners and alternating bits.
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, PIX_MAX);
    send_pixel(PIX_MAX, 0);
    send_pixel(2730, 1365);
    send_pixel(1365, 2730);
    drain_pipeline();

    // A typical barrel lens with the principal point on an exact pixel.
    load_regs(cfg_t'{24'd33554, 24'd33554, 16'd5120, 16'd3840,
                     -32'sd53687091, 32'sd13421773, 32'sd268435, -32'sd268435});
    send_pixel(320, 240);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(320, 0);
    send_pixel(0, 240);
    drain_pipeline();

    // Largest scale with extreme coefficients: saturation all over the datapath.
    load_regs(cfg_t'{24'hFF_FFFF, 24'hFF_FFFF, 16'd0, 16'd0,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel(0, 0);
    send_pixel(1, 1);
    drain_pipeline();

    load_regs(cfg_t'{24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    send_pixel(0, 0);
    send_pixel(PIX_MAX, 0);
    drain_pipeline();

    // A zero reciprocal focal length collapses xd; the smallest legal one on y.
    load_regs(cfg_t'{24'd0, 24'd1, 16'hFFFF, 16'd0,
                     -32'sd53687091, 32'sd13421773, 32'sd268435, -32'sd268435});
    send_pixel(100, 200);
    send_pixel(PIX_MAX, PIX_MAX);
    drain_pipeline();

    // The xd*yd product lands exactly on a half, once negative and once positive.
    load_regs(cfg_t'{24'd512, 24'd512, 16'd0, 16'd192,
                     32'sd0, 32'sd0, 32'sh1000_0000, 32'sd0});
    send_pixel(1, 6);
    send_pixel(1, 18);
    drain_pipeline();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on <= (ph != QUIET_PHASE);
      load_regs(draw_lens_setting(ph % 3 == 2));
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if (ph == HOLD_PHASE && n == 30) hold_reqs <= hold_reqs + 1'b1;
        if (ph == PAUSE_PHASE && n == PHASE_PIXELS / 2) drain_pipeline();
        col = $urandom_range(PIX_MAX);
        row = $urandom_range(PIX_MAX);
        if ($urandom_range(15) == 0) col = PIX_MAX * $urandom_range(1);
        if ($urandom_range(15) == 0) row = PIX_MAX * $urandom_range(1);
        send_pixel(col, row);
      end
      drain_pipeline();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("pixel_lens_distortion_map verification clean");
    end else begin
      $display("pixel_lens_distortion_map verification failed");
    end
    $finish;
  end

endmodule
